// ----- rtl/sale_pkg.sv -----
// Shared types and codes for the sorted array list engine.
// Holds the request/result payload structs and the controller-to-datapath
// command and status bundles. No dependencies.
package sale_pkg;

  localparam int LIST_DEPTH_DEF = 64;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_ORDERED = 3'd2;
  localparam logic [2:0] OP_DELETE  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic        [2:0]  op;
    logic        [6:0]  position;
    logic signed [15:0] new_coefficient;
    logic signed [15:0] new_exponent;
  } sale_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [15:0] out_coefficient;
    logic signed [15:0] out_exponent;
    logic        [6:0]  entry_total;
    logic        [31:0] shifts_done;
  } sale_out_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic signed [15:0] exponent;
  } sale_entry_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_POS,
    CUR_TOP,
    CUR_ZERO,
    CUR_INC,
    CUR_DEC
  } sale_cur_op_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_CUR,
    POS_FILL
  } sale_pos_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DN,
    WR_NEW
  } sale_wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INS,
    CNT_DEL,
    CNT_CLR
  } sale_cnt_op_t;

  typedef struct packed {
    logic         req_load;
    sale_cur_op_t cur_op;
    sale_pos_op_t pos_op;
    logic         rd_en;
    sale_wr_op_t  wr_op;
    logic         cap_en;
    sale_cnt_op_t cnt_op;
    logic         st_set;
    logic [1:0]   st_code;
    logic         out_load;
  } sale_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_lt_fill;
    logic       pos_le_fill;
    logic       full;
    logic       fill_zero;
    logic       ins_at_end;
    logic       cur_at_pos;
    logic       cur_last;
    logic       key_gt;
    logic       out_free;
  } sale_sts_t;

endpackage

// ----- rtl/sale_datapath.sv -----
// Datapath of the sorted array list engine: entry memory, cursor, counters
// and the result register. Driven by sale_ctrl commands; uses sale_pkg.
module sale_datapath #(
  parameter int LIST_DEPTH = sale_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sale_pkg::sale_in_t  in_data,
  input  logic                out_ready,
  output logic                out_valid,
  output sale_pkg::sale_out_t out_data,
  input  sale_pkg::sale_cmd_t cmd,
  output sale_pkg::sale_sts_t sts
);

  localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  sale_pkg::sale_entry_t mem [LIST_DEPTH];
  sale_pkg::sale_entry_t rd_data_r;
  sale_pkg::sale_entry_t res_entry_r;
  sale_pkg::sale_entry_t wr_data;
  sale_pkg::sale_in_t    req_r;
  sale_pkg::sale_out_t   out_data_r;

  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] fill_m1;
  logic [CW-1:0] gap;
  logic [31:0]   moves_r, moves_nxt;
  logic [1:0]    status_r;
  logic          out_valid_r;
  logic [CMPW-1:0] fill_ext;
  logic [CMPW-1:0] reqpos_ext;

  assign fill_m1    = fill_r - CW'(1);
  assign gap        = fill_r - CW'(pos_r);
  assign fill_ext   = CMPW'(fill_r);
  assign reqpos_ext = CMPW'(req_r.position);

  assign sts.op          = req_r.op;
  assign sts.pos_lt_fill = reqpos_ext < fill_ext;
  assign sts.pos_le_fill = reqpos_ext <= fill_ext;
  assign sts.full        = fill_r >= CW'(LIST_DEPTH);
  assign sts.fill_zero   = fill_r == '0;
  assign sts.ins_at_end  = CW'(pos_r) == fill_r;
  assign sts.cur_at_pos  = cur_r == pos_r;
  assign sts.cur_last    = (CW'(cur_r) + CW'(1)) == fill_r;
  assign sts.key_gt      = $signed(rd_data_r.exponent) > $signed(req_r.new_exponent);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    case (cmd.cur_op)
      sale_pkg::CUR_POS:  cur_nxt = pos_r;
      sale_pkg::CUR_TOP:  cur_nxt = fill_m1[AW-1:0];
      sale_pkg::CUR_ZERO: cur_nxt = '0;
      sale_pkg::CUR_INC:  cur_nxt = cur_r + AW'(1);
      sale_pkg::CUR_DEC:  cur_nxt = cur_r - AW'(1);
      default:            cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    if (cmd.req_load) begin
      pos_nxt = AW'(in_data.position);
    end else begin
      case (cmd.pos_op)
        sale_pkg::POS_CUR:  pos_nxt = cur_r;
        sale_pkg::POS_FILL: pos_nxt = fill_r[AW-1:0];
        default:            pos_nxt = pos_r;
      endcase
    end
  end

  always_comb begin
    case (cmd.wr_op)
      sale_pkg::WR_UP:  wr_addr = cur_r + AW'(1);
      sale_pkg::WR_DN:  wr_addr = cur_r - AW'(1);
      sale_pkg::WR_NEW: wr_addr = pos_r;
      default:          wr_addr = cur_r;
    endcase
    if (cmd.wr_op == sale_pkg::WR_NEW) begin
      wr_data.coefficient = req_r.new_coefficient;
      wr_data.exponent    = req_r.new_exponent;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_comb begin
    fill_nxt  = fill_r;
    moves_nxt = moves_r;
    case (cmd.cnt_op)
      sale_pkg::CNT_INS: begin
        fill_nxt  = fill_r + CW'(1);
        moves_nxt = moves_r + 32'(gap);
      end
      sale_pkg::CNT_DEL: begin
        fill_nxt  = fill_m1;
        moves_nxt = moves_r + 32'(gap - CW'(1));
      end
      sale_pkg::CNT_CLR: begin
        fill_nxt  = '0;
        moves_nxt = '0;
      end
      default: begin
        fill_nxt  = fill_r;
        moves_nxt = moves_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op != sale_pkg::WR_NONE) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    if (cmd.req_load) begin
      req_r       <= in_data;
      res_entry_r <= '0;
      status_r    <= sale_pkg::ST_OK;
    end else begin
      if (cmd.cap_en) begin
        res_entry_r <= rd_data_r;
      end
      if (cmd.st_set) begin
        status_r <= cmd.st_code;
      end
    end
    if (cmd.out_load) begin
      out_data_r.status          <= status_r;
      out_data_r.out_coefficient <= res_entry_r.coefficient;
      out_data_r.out_exponent    <= res_entry_r.exponent;
      out_data_r.entry_total     <= fill_ext[6:0];
      out_data_r.shifts_done     <= moves_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      moves_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      moves_r <= moves_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(LIST_DEPTH))
    else $error("fill count above list depth");

  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CW'(cur_r) < fill_r))
    else $error("read of an entry beyond the fill count");

  a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_op == sale_pkg::WR_NEW |=> fill_r == $past(fill_r) + CW'(1))
    else $error("new entry written without fill count growth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_op == sale_pkg::CNT_CLR |=> (fill_r == '0 && moves_r == '0))
    else $error("clear left counters nonzero");
`endif

endmodule

// ----- rtl/sale_ctrl.sv -----
// Controller state machine of the sorted array list engine.
// Sequences search, shift and result steps; uses sale_pkg command/status types.
module sale_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sale_pkg::sale_sts_t sts,
  output sale_pkg::sale_cmd_t cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DECODE   = 14'b00000000000010,
    S_SRCH_RD  = 14'b00000000000100,
    S_SRCH_CMP = 14'b00000000001000,
    S_OPEN     = 14'b00000000010000,
    S_UP_RD    = 14'b00000000100000,
    S_UP_WR    = 14'b00000001000000,
    S_NEW      = 14'b00000010000000,
    S_GET_RD   = 14'b00000100000000,
    S_GET_CAP  = 14'b00001000000000,
    S_DN_RD    = 14'b00010000000000,
    S_DN_WR    = 14'b00100000000000,
    S_DEL_END  = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.cur_op  = sale_pkg::CUR_HOLD;
    cmd.pos_op  = sale_pkg::POS_HOLD;
    cmd.wr_op   = sale_pkg::WR_NONE;
    cmd.cnt_op  = sale_pkg::CNT_HOLD;
    cmd.st_code = sale_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op) inside
          sale_pkg::OP_READ, sale_pkg::OP_DELETE: begin
            if (!sts.pos_lt_fill) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = sale_pkg::ST_BAD_INDEX;
              state_nxt   = S_FINISH;
            end else begin
              cmd.cur_op = sale_pkg::CUR_POS;
              state_nxt  = S_GET_RD;
            end
          end
          sale_pkg::OP_INSERT: begin
            if (!sts.pos_le_fill) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = sale_pkg::ST_BAD_INDEX;
              state_nxt   = S_FINISH;
            end else if (sts.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = sale_pkg::ST_FULL;
              state_nxt   = S_FINISH;
            end else begin
              state_nxt = S_OPEN;
            end
          end
          sale_pkg::OP_ORDERED: begin
            if (sts.full) begin
              cmd.st_set  = 1'b1;
              cmd.st_code = sale_pkg::ST_FULL;
              state_nxt   = S_FINISH;
            end else if (sts.fill_zero) begin
              cmd.pos_op = sale_pkg::POS_FILL;
              state_nxt  = S_OPEN;
            end else begin
              cmd.cur_op = sale_pkg::CUR_ZERO;
              state_nxt  = S_SRCH_RD;
            end
          end
          sale_pkg::OP_CLEAR: begin
            cmd.cnt_op = sale_pkg::CNT_CLR;
            state_nxt  = S_FINISH;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (sts.key_gt) begin
          cmd.pos_op = sale_pkg::POS_CUR;
          state_nxt  = S_OPEN;
        end else if (sts.cur_last) begin
          cmd.pos_op = sale_pkg::POS_FILL;
          state_nxt  = S_OPEN;
        end else begin
          cmd.cur_op = sale_pkg::CUR_INC;
          state_nxt  = S_SRCH_RD;
        end
      end
      S_OPEN: begin
        if (sts.ins_at_end) begin
          state_nxt = S_NEW;
        end else begin
          cmd.cur_op = sale_pkg::CUR_TOP;
          state_nxt  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_op = sale_pkg::WR_UP;
        if (sts.cur_at_pos) begin
          state_nxt = S_NEW;
        end else begin
          cmd.cur_op = sale_pkg::CUR_DEC;
          state_nxt  = S_UP_RD;
        end
      end
      S_NEW: begin
        cmd.wr_op  = sale_pkg::WR_NEW;
        cmd.cnt_op = sale_pkg::CNT_INS;
        state_nxt  = S_FINISH;
      end
      S_GET_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd.cap_en = 1'b1;
        if (sts.op == sale_pkg::OP_READ) begin
          state_nxt = S_FINISH;
        end else if (sts.cur_last) begin
          state_nxt = S_DEL_END;
        end else begin
          cmd.cur_op = sale_pkg::CUR_INC;
          state_nxt  = S_DN_RD;
        end
      end
      S_DN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_op = sale_pkg::WR_DN;
        if (sts.cur_last) begin
          state_nxt = S_DEL_END;
        end else begin
          cmd.cur_op = sale_pkg::CUR_INC;
          state_nxt  = S_DN_RD;
        end
      end
      S_DEL_END: begin
        cmd.cnt_op = sale_pkg::CNT_DEL;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_IDLE)
    else $error("result load did not return to idle");

  a_write_in_move: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_op == sale_pkg::WR_UP || cmd.wr_op == sale_pkg::WR_DN)
      |-> $past(cmd.rd_en))
    else $error("entry move without a preceding read");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.req_load |=> state_r == S_DECODE)
    else $error("accepted request not decoded");
`endif

endmodule

// ----- rtl/sorted_array_list_engine_core.sv -----
// Top level of the sorted array list engine.
// Joins sale_ctrl and sale_datapath; uses sale_pkg payload types.
//
// Usage:
//   in_valid/in_ready/in_data carry one request: read, insert at index,
//   ordered insert by exponent, delete, or clear. out_valid/out_ready/out_data
//   return exactly one result per request: status, entry read or removed,
//   entry count and running move count.
//   Entries live in a single-port-write, registered-read memory; each entry
//   move takes one read and one write.
//   One request is in work at a time; the next is taken in the cycle after
//   the result is loaded.
//   A loaded result waiting on out_ready does not block the next request;
//   only the following result load waits for the output register to drain.
//   Reset clears the entry count, move count and output valid; memory
//   contents need no clearing since only entries below the count are read.
module sorted_array_list_engine_core #(
  parameter int LIST_DEPTH = sale_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sale_pkg::sale_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sale_pkg::sale_out_t out_data
);

  sale_pkg::sale_cmd_t cmd;
  sale_pkg::sale_sts_t sts;

  sale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sale_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- sim/sorted_array_list_engine_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_array_list_engine_core: a directed request table, then
// random grow/shrink/mixed traffic; results checked against the table or a list model.
// Depends on sale_pkg and the engine RTL.
module sorted_array_list_engine_core_tb;

  localparam int DEPTH = sale_pkg::LIST_DEPTH_DEF;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_REQUESTS = 1050;

  typedef enum int {TRAFFIC_GROW, TRAFFIC_SHRINK, TRAFFIC_MIXED} traffic_mode_t;

  typedef struct {
    sale_pkg::sale_in_t  req;
    bit                  typed;
    sale_pkg::sale_out_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sale_pkg::sale_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sale_pkg::sale_out_t out_data;

  sale_pkg::sale_entry_t shadow_entries [DEPTH];
  int                    shadow_fill = 0;
  logic [31:0]           shadow_moves = '0;

  sale_pkg::sale_out_t pending_results [$];
  sale_pkg::sale_out_t head_result;
  plan_row_t           plan [$];
  int                  mismatch_count = 0;
  bit                  no_idle = 1'b0;

  sorted_array_list_engine_core #(.LIST_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic sale_pkg::sale_in_t make_request(logic [2:0] op, logic [6:0] pos,
                                                      logic signed [15:0] coef,
                                                      logic signed [15:0] expo);
    sale_pkg::sale_in_t r;
    r.op = op;
    r.position = pos;
    r.new_coefficient = coef;
    r.new_exponent = expo;
    return r;
  endfunction

  function automatic sale_pkg::sale_out_t known_result(logic [1:0] st,
                                                       logic signed [15:0] coef,
                                                       logic signed [15:0] expo,
                                                       logic [6:0] total,
                                                       logic [31:0] moves);
    sale_pkg::sale_out_t r;
    r.status = st;
    r.out_coefficient = coef;
    r.out_exponent = expo;
    r.entry_total = total;
    r.shifts_done = moves;
    return r;
  endfunction

  function automatic void open_slot(int at);
    for (int k = shadow_fill; k > at; k--) begin
      shadow_entries[k] = shadow_entries[k - 1];
      shadow_moves++;
    end
  endfunction

  function automatic sale_pkg::sale_out_t apply_list_request(sale_pkg::sale_in_t req);
    sale_pkg::sale_out_t r;
    int slot;
    r = '0;
    r.status = sale_pkg::ST_OK;
    case (req.op)
      sale_pkg::OP_READ: begin
        if (int'(req.position) >= shadow_fill) begin
          r.status = sale_pkg::ST_BAD_INDEX;
        end else begin
          r.out_coefficient = shadow_entries[req.position].coefficient;
          r.out_exponent = shadow_entries[req.position].exponent;
        end
      end
      sale_pkg::OP_INSERT: begin
        if (int'(req.position) > shadow_fill) begin
          r.status = sale_pkg::ST_BAD_INDEX;
        end else if (shadow_fill >= DEPTH) begin
          r.status = sale_pkg::ST_FULL;
        end else begin
          open_slot(int'(req.position));
          shadow_entries[req.position].coefficient = req.new_coefficient;
          shadow_entries[req.position].exponent = req.new_exponent;
          shadow_fill++;
        end
      end
      sale_pkg::OP_ORDERED: begin
        if (shadow_fill >= DEPTH) begin
          r.status = sale_pkg::ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_fill &&
                 $signed(shadow_entries[slot].exponent) <= $signed(req.new_exponent)) begin
            slot++;
          end
          open_slot(slot);
          shadow_entries[slot].coefficient = req.new_coefficient;
          shadow_entries[slot].exponent = req.new_exponent;
          shadow_fill++;
        end
      end
      sale_pkg::OP_DELETE: begin
        if (int'(req.position) >= shadow_fill) begin
          r.status = sale_pkg::ST_BAD_INDEX;
        end else begin
          r.out_coefficient = shadow_entries[req.position].coefficient;
          r.out_exponent = shadow_entries[req.position].exponent;
          for (int k = int'(req.position); k + 1 < shadow_fill; k++) begin
            shadow_entries[k] = shadow_entries[k + 1];
            shadow_moves++;
          end
          shadow_fill--;
        end
      end
      sale_pkg::OP_CLEAR: begin
        shadow_fill = 0;
        shadow_moves = '0;
      end
      default: ;
    endcase
    r.entry_total = 7'(shadow_fill);
    r.shifts_done = shadow_moves;
    return r;
  endfunction

  function automatic sale_pkg::sale_in_t random_request(traffic_mode_t mode);
    sale_pkg::sale_in_t r;
    int pick;
    int top;
    pick = $urandom_range(0, 99);
    case (mode)
      TRAFFIC_GROW: begin
        r.op = pick < 45 ? sale_pkg::OP_INSERT :
               pick < 85 ? sale_pkg::OP_ORDERED :
               pick < 91 ? sale_pkg::OP_READ :
               pick < 97 ? sale_pkg::OP_DELETE :
               3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      TRAFFIC_SHRINK: begin
        r.op = pick < 50 ? sale_pkg::OP_DELETE :
               pick < 70 ? sale_pkg::OP_READ :
               pick < 80 ? sale_pkg::OP_INSERT :
               pick < 92 ? sale_pkg::OP_ORDERED :
               pick < 94 ? sale_pkg::OP_CLEAR :
               3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      default: begin
        r.op = pick < 20 ? sale_pkg::OP_READ :
               pick < 40 ? sale_pkg::OP_INSERT :
               pick < 62 ? sale_pkg::OP_ORDERED :
               pick < 86 ? sale_pkg::OP_DELETE :
               pick < 88 ? sale_pkg::OP_CLEAR :
               pick < 91 ? 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)) :
               sale_pkg::OP_READ;
      end
    endcase
    top = (r.op == sale_pkg::OP_INSERT) ? shadow_fill
                                        : (shadow_fill > 0 ? shadow_fill - 1 : 0);
    if ($urandom_range(0, 99) < 12) begin
      r.position = 7'($urandom);
    end else begin
      r.position = 7'($urandom_range(0, top));
    end
    r.new_coefficient = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.new_exponent = 16'($urandom_range(0, 7)) - 16'sd4;
    end else if (pick < 41) begin
      r.new_exponent = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else begin
      r.new_exponent = 16'($urandom);
    end
    return r;
  endfunction

  task automatic issue_request(sale_pkg::sale_in_t req, bit typed,
                               sale_pkg::sale_out_t want);
    sale_pkg::sale_out_t predicted;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_request(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_sender();
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(out_data.status));
        check_field("out_coefficient", 32'(head_result.out_coefficient),
                    32'(out_data.out_coefficient));
        check_field("out_exponent", 32'(head_result.out_exponent),
                    32'(out_data.out_exponent));
        check_field("entry_total", 32'(head_result.entry_total), 32'(out_data.entry_total));
        check_field("shifts_done", head_result.shifts_done, out_data.shifts_done);
      end
    end
  end

  initial begin
    traffic_mode_t seg_mode;
    seg_mode = TRAFFIC_GROW;
    plan.push_back('{make_request(sale_pkg::OP_READ, 0, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{make_request(sale_pkg::OP_DELETE, 0, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{make_request(sale_pkg::OP_INSERT, 1, 7, 7), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{make_request(sale_pkg::OP_INSERT, 0, 16'sh7fff, 16'sh8000), 1'b1,
                     known_result(sale_pkg::ST_OK, 0, 0, 1, 0)});
    plan.push_back('{make_request(sale_pkg::OP_INSERT, 0, 16'sh8000, 16'sh7fff), 1'b1,
                     known_result(sale_pkg::ST_OK, 0, 0, 2, 1)});
    plan.push_back('{make_request(sale_pkg::OP_READ, 1, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_OK, 16'sh7fff, 16'sh8000, 2, 1)});
    plan.push_back('{make_request(sale_pkg::OP_READ, 7'h7f, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 2, 1)});
    plan.push_back('{make_request(sale_pkg::OP_INSERT, 7'h7f, -1, -1), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 2, 1)});
    plan.push_back('{make_request(sale_pkg::OP_ORDERED, 0, 1, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_ORDERED, 0, 2, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_ORDERED, 0, 3, 16'sh8000), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_ORDERED, 0, 4, 16'sh7fff), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_INSERT, 6, -1, -1), 1'b0, '0});
    plan.push_back('{make_request(OP_SPARE_LO, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_request(OP_SPARE_LO + 3'd1, 3, 5, 5), 1'b0, '0});
    plan.push_back('{make_request(OP_SPARE_HI, 7'd64, -1, -1), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_DELETE, 0, 0, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_DELETE, 5, 0, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_DELETE, 7'd64, 0, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_READ, 2, 0, 0), 1'b0, '0});
    plan.push_back('{make_request(sale_pkg::OP_CLEAR, 0, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_OK, 0, 0, 0, 0)});
    plan.push_back('{make_request(sale_pkg::OP_READ, 0, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_BAD_INDEX, 0, 0, 0, 0)});
    plan.push_back('{make_request(sale_pkg::OP_ORDERED, 0, -5, 100), 1'b1,
                     known_result(sale_pkg::ST_OK, 0, 0, 1, 0)});
    plan.push_back('{make_request(sale_pkg::OP_CLEAR, 0, 0, 0), 1'b1,
                     known_result(sale_pkg::ST_OK, 0, 0, 0, 0)});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      issue_request(plan[i].req, plan[i].typed, plan[i].want);
      idle_sender();
    end
    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        seg_mode = (n < 200) ? traffic_mode_t'(n / 100)
                             : traffic_mode_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) drain_results();
      end
      no_idle = (n >= 500 && n < 700);
      issue_request(random_request(seg_mode), 1'b0, '0);
      idle_sender();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
